// ===== rtl/hpl_pkg.sv =====
// ----------------------------------------------------------------------------
// hpl_pkg: shared types and constants for the path length block
// Fixed-point formats, CORDIC angle table, sequencer states and register
// indexes used by the interfaces and the top level.
// ----------------------------------------------------------------------------
package hpl_pkg;

    localparam int TOTAL_FRACTION_BITS = 16;
    localparam int TOTAL_W = 32 + TOTAL_FRACTION_BITS;

    localparam int LAT_W = 31;
    localparam int LON_W = 32;
    localparam int METERS_W = 32;
    localparam int CFG_DATA_W = 32;

    // Datapath widths: Q32 magnitudes up to 1.0 need 33 bits.
    localparam int Q_W = 33;
    localparam int CW = 36;
    localparam int ANG_W = 34;
    localparam int PROD_W = 2 * Q_W;
    localparam int REM_W = 35;
    localparam int SQN_W = 66;

    localparam int CORDIC_LAST = 31;
    localparam int SQRT_LAST = 32;

    localparam logic [Q_W-1:0] RAD_PER_E7 = 33'd4024455254;
    localparam logic [Q_W-1:0] RADIUS_X2 = 33'd12742000;
    localparam logic [Q_W-1:0] ONE_Q32_U = 33'h1_0000_0000;

    localparam logic signed [CW-1:0] ONE_Q32 = 36'sd4294967296;
    localparam logic signed [CW-1:0] NEG_ONE_Q32 = -36'sd4294967296;
    localparam logic signed [CW-1:0] PI_Q32 = 36'sd13493037705;
    localparam logic signed [CW-1:0] HALF_PI_Q32 = 36'sd6746518852;
    localparam logic signed [CW-1:0] NEG_HALF_PI_Q32 = -36'sd6746518852;
    localparam logic signed [CW-1:0] GAIN_Q32 = 36'sd2608131496;

    localparam logic signed [ANG_W-1:0] FULL_TURN_E7 = 34'sd3600000000;
    localparam logic signed [ANG_W-1:0] NEG_FULL_TURN_E7 = -34'sd3600000000;
    localparam logic signed [ANG_W-1:0] HALF_TURN_E7 = 34'sd1800000000;
    localparam logic signed [ANG_W-1:0] NEG_HALF_TURN_E7 = -34'sd1800000000;

    localparam logic [PROD_W-1:0] RND_SHIFT30 = 66'd1 << 29;
    localparam logic [PROD_W-1:0] RND_SHIFT29 = 66'd1 << 28;

    localparam int SEG_SHIFT = 32 - TOTAL_FRACTION_BITS;
    localparam logic [PROD_W-1:0] SEG_ROUND = 66'd1 << (SEG_SHIFT - 1);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [TOTAL_W:0] METERS_HALF = (TOTAL_W+1)'(1) << (TOTAL_FRACTION_BITS - 1);

    typedef enum logic [0:0] {
        CFG_LIMIT_METERS = 1'b0,
        CFG_OVER_MODE    = 1'b1
    } cfg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ANGLE,
        S_SCALE,
        S_ROTATE,
        S_ROT_STORE,
        S_MUL_AA,
        S_MUL_CC,
        S_MUL_SS,
        S_MUL_T,
        S_COMBINE,
        S_SQRT_LOAD,
        S_SQRT,
        S_VEC_LOAD,
        S_VECTOR,
        S_DIST,
        S_ACCUM,
        S_DONE
    } state_t;

    // atan(2^-i) in Q32.
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd3373259426;
            5'd1:  v = 32'd1991351318;
            5'd2:  v = 32'd1052175346;
            5'd3:  v = 32'd534100635;
            5'd4:  v = 32'd268086748;
            5'd5:  v = 32'd134174063;
            5'd6:  v = 32'd67103403;
            5'd7:  v = 32'd33553749;
            5'd8:  v = 32'd16777131;
            5'd9:  v = 32'd8388597;
            5'd10: v = 32'd4194303;
            5'd11: v = 32'd2097152;
            5'd12: v = 32'd1048576;
            5'd13: v = 32'd524288;
            5'd14: v = 32'd262144;
            5'd15: v = 32'd131072;
            5'd16: v = 32'd65536;
            5'd17: v = 32'd32768;
            5'd18: v = 32'd16384;
            5'd19: v = 32'd8192;
            5'd20: v = 32'd4096;
            5'd21: v = 32'd2048;
            5'd22: v = 32'd1024;
            5'd23: v = 32'd512;
            5'd24: v = 32'd256;
            5'd25: v = 32'd128;
            5'd26: v = 32'd64;
            5'd27: v = 32'd32;
            5'd28: v = 32'd16;
            5'd29: v = 32'd8;
            5'd30: v = 32'd4;
            5'd31: v = 32'd2;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/hpl_in_if.sv =====
// ----------------------------------------------------------------------------
// hpl_in_if: path point request channel
// Valid/ready channel carrying one path point per request.
// ----------------------------------------------------------------------------
interface hpl_in_if;
    import hpl_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] latitude_e7;
    logic signed [LON_W-1:0] longitude_e7;
    logic                    first_point;
    logic                    last_point;

    modport source (
        output valid,
        output latitude_e7,
        output longitude_e7,
        output first_point,
        output last_point,
        input  ready
    );

    modport sink (
        input  valid,
        input  latitude_e7,
        input  longitude_e7,
        input  first_point,
        input  last_point,
        output ready
    );

endinterface

// ===== rtl/hpl_out_if.sv =====
// ----------------------------------------------------------------------------
// hpl_out_if: path length result channel
// Valid/ready channel carrying one path total per request.
// ----------------------------------------------------------------------------
interface hpl_out_if;
    import hpl_pkg::*;

    logic                valid;
    logic                ready;
    logic [METERS_W-1:0] path_meters;
    logic                limit_hit;

    modport source (
        output valid,
        output path_meters,
        output limit_hit,
        input  ready
    );

    modport sink (
        input  valid,
        input  path_meters,
        input  limit_hit,
        output ready
    );

endinterface

// ===== rtl/haversine_path_length.sv =====
// A path start point goes from acceptance straight to S_DONE before ready returns.
// Every further point runs four 32-step CORDIC rotations,
// two 33-step square roots and one 32-step CORDIC vectoring on a shared unit.
// One new point is taken at a time; a result is registered as a last point
// leaves S_DONE, and a last point waits while the prior result is unread.
// Reset clears the total, the path state, the output valid and the config registers; datapath registers are not reset.
// ----------------------------------------------------------------------------
// haversine_path_length: great-circle length of a path of points
// Accumulates haversine segment lengths in fixed point with one shared
// multiplier, one CORDIC unit and one bit-serial square root.
// ----------------------------------------------------------------------------
module haversine_path_length (
    input  logic                                  clk,
    input  logic                                  rst_n,
    hpl_in_if.sink                                in_ch,
    hpl_out_if.source                             out_ch,
    input  logic                                  cfg_we,
    input  hpl_pkg::cfg_idx_t                     cfg_index,
    input  logic [hpl_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
    import hpl_pkg::*;

    state_t state_reg, state_next;

    logic [1:0] job_reg;
    logic [5:0] step_reg;

    logic signed [LAT_W-1:0] cur_lat_reg, prev_lat_reg;
    logic signed [LON_W-1:0] cur_lon_reg, prev_lon_reg;
    logic last_reg;
    logic have_prev_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic [PROD_W-1:0] prod_reg;
    logic neg_reg, flip_reg;
    logic signed [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic [Q_W-1:0] m1_reg, m2_reg, mc1_reg, mc2_reg;
    logic cneg1_reg, cneg2_reg;
    logic [Q_W-1:0] a_reg, pc_reg;
    logic [SQN_W-1:0] sq_n_reg;
    logic [REM_W-1:0] sq_rem_reg;
    logic [Q_W-1:0] sq_root_reg, sx_reg, sy_reg;

    logic out_valid_reg;
    logic [METERS_W-1:0] path_meters_reg;
    logic limit_hit_reg;
    logic [METERS_W-1:0] limit_reg;
    logic over_reg;

    function automatic logic signed [ANG_W-1:0] wrap_e7(input logic signed [ANG_W-1:0] v);
        logic signed [ANG_W-1:0] r;
        r = v;
        if (r >= FULL_TURN_E7)
            r = r - FULL_TURN_E7;
        else if (r <= NEG_FULL_TURN_E7)
            r = r + FULL_TURN_E7;
        if (r > HALF_TURN_E7)
            r = r - FULL_TURN_E7;
        else if (r <= NEG_HALF_TURN_E7)
            r = r + FULL_TURN_E7;
        return r;
    endfunction

    function automatic logic signed [CW-1:0] clamp_unit(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = v;
        if (v > ONE_Q32)
            r = ONE_Q32;
        else if (v < NEG_ONE_Q32)
            r = NEG_ONE_Q32;
        return r;
    endfunction

    function automatic logic [Q_W-1:0] abs_q(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = v[CW-1] ? -v : v;
        return r[Q_W-1:0];
    endfunction

    // Angle source: the latitude and longitude differences (halved when scaled), then the two latitudes.
    logic signed [ANG_W-1:0] ang_src, ang_wrap, ang_abs;
    logic [LAT_W-1:0] ang_mag;

    always_comb
    begin
        unique case (job_reg)
            2'd0: ang_src = {{3{cur_lat_reg[LAT_W-1]}}, cur_lat_reg}
                          - {{3{prev_lat_reg[LAT_W-1]}}, prev_lat_reg};
            2'd1: ang_src = {{2{cur_lon_reg[LON_W-1]}}, cur_lon_reg}
                          - {{2{prev_lon_reg[LON_W-1]}}, prev_lon_reg};
            2'd2: ang_src = {{3{prev_lat_reg[LAT_W-1]}}, prev_lat_reg};
            2'd3: ang_src = {{3{cur_lat_reg[LAT_W-1]}}, cur_lat_reg};
        endcase
        ang_wrap = wrap_e7(ang_src);
        ang_abs = ang_wrap[ANG_W-1] ? -ang_wrap : ang_wrap;
        ang_mag = ang_abs[LAT_W-1:0];
    end

    // Radian scaling and the fold of latitudes beyond a quarter turn.
    logic [PROD_W-1:0] scale_sum, scale_shift;
    logic signed [CW-1:0] rad_ext, z_signed, z_fold;
    logic z_flip;

    always_comb
    begin
        scale_sum = prod_reg + (job_reg[1] ? RND_SHIFT29 : RND_SHIFT30);
        scale_shift = job_reg[1] ? (scale_sum >> 29) : (scale_sum >> 30);
        rad_ext = {1'b0, scale_shift[CW-2:0]};
        z_signed = neg_reg ? -rad_ext : rad_ext;
        z_fold = z_signed;
        z_flip = 1'b0;
        if (job_reg[1] && (z_signed > HALF_PI_Q32))
        begin
            z_fold = z_signed - PI_Q32;
            z_flip = 1'b1;
        end
        else if (job_reg[1] && (z_signed < NEG_HALF_PI_Q32))
        begin
            z_fold = z_signed + PI_Q32;
            z_flip = 1'b1;
        end
    end

    // Shared CORDIC step for both rotation and vectoring.
    logic signed [CW-1:0] cd_dx, cd_dy, cd_at, cx_step, cy_step, cz_step;
    logic cd_up;

    always_comb
    begin
        cd_dx = cx_reg >>> step_reg[4:0];
        cd_dy = cy_reg >>> step_reg[4:0];
        cd_at = {4'b0, atan_entry(step_reg[4:0])};
        cd_up = (state_reg == S_ROTATE) ? !cz_reg[CW-1] : cy_reg[CW-1];
        if (cd_up)
        begin
            cx_step = cx_reg - cd_dy;
            cy_step = cy_reg + cd_dx;
            cz_step = cz_reg - cd_at;
        end
        else
        begin
            cx_step = cx_reg + cd_dy;
            cy_step = cy_reg - cd_dx;
            cz_step = cz_reg + cd_at;
        end
    end

    // Rotation results: cosine in x, sine in y.
    logic signed [CW-1:0] rot_cos, rot_cos_c, rot_sin;

    always_comb
    begin
        rot_cos_c = clamp_unit(cx_reg);
        rot_cos = flip_reg ? -rot_cos_c : rot_cos_c;
        rot_sin = clamp_unit(cy_reg);
    end

    // Haversine term a = sin^2(dlat/2) +- |cos1 cos2| sin^2(dlon/2).
    logic signed [CW-1:0] a_sum;
    logic [Q_W-1:0] a_clamped, sq_in;

    always_comb
    begin
        if (cneg1_reg ^ cneg2_reg)
            a_sum = $signed({3'b0, a_reg}) - $signed({3'b0, prod_reg[64:32]});
        else
            a_sum = $signed({3'b0, a_reg}) + $signed({3'b0, prod_reg[64:32]});
        if (a_sum[CW-1])
            a_clamped = '0;
        else if (a_sum > ONE_Q32)
            a_clamped = ONE_Q32_U;
        else
            a_clamped = a_sum[Q_W-1:0];
        sq_in = (job_reg == 2'd0) ? (ONE_Q32_U - a_reg) : a_reg;
    end

    // One result bit per step of the square root.
    logic [REM_W+1:0] sq_rem_sh, sq_trial;
    logic sq_ge;
    logic [REM_W-1:0] sq_rem_step;
    logic [Q_W-1:0] sq_root_step;

    always_comb
    begin
        sq_rem_sh = {sq_rem_reg, sq_n_reg[SQN_W-1:SQN_W-2]};
        sq_trial = {2'b0, sq_root_reg, 2'b01};
        sq_ge = (sq_rem_sh >= sq_trial);
        sq_rem_step = sq_ge ? REM_W'(sq_rem_sh - sq_trial) : sq_rem_sh[REM_W-1:0];
        sq_root_step = {sq_root_reg[Q_W-2:0], sq_ge};
    end

    // Shared multiplier operand selection.
    logic [Q_W-1:0] mul_a, mul_b, dist_z;

    always_comb
    begin
        dist_z = cz_reg[CW-1] ? '0 : cz_reg[Q_W-1:0];
        unique case (state_reg)
            S_ANGLE:
            begin
                mul_a = {2'b0, ang_mag};
                mul_b = RAD_PER_E7;
            end
            S_MUL_AA:
            begin
                mul_a = m1_reg;
                mul_b = m1_reg;
            end
            S_MUL_CC:
            begin
                mul_a = mc1_reg;
                mul_b = mc2_reg;
            end
            S_MUL_SS:
            begin
                mul_a = m2_reg;
                mul_b = m2_reg;
            end
            S_MUL_T:
            begin
                mul_a = pc_reg;
                mul_b = prod_reg[64:32];
            end
            S_DIST:
            begin
                mul_a = dist_z;
                mul_b = RADIUS_X2;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Segment rounding, saturating accumulation and the final total.
    logic [PROD_W-1:0] seg_val, acc_sum;
    logic [TOTAL_W:0] meters_rnd;
    logic [METERS_W:0] meters_wide;
    logic [METERS_W-1:0] meters;
    logic hit;
    logic start_path, emit, accept;

    always_comb
    begin
        seg_val = (prod_reg + SEG_ROUND) >> SEG_SHIFT;
        acc_sum = {{(PROD_W-TOTAL_W){1'b0}}, total_reg} + seg_val;
        meters_rnd = {1'b0, total_reg} + METERS_HALF;
        meters_wide = meters_rnd[TOTAL_W:TOTAL_FRACTION_BITS];
        meters = meters_wide[METERS_W] ? {METERS_W{1'b1}} : meters_wide[METERS_W-1:0];
        hit = over_reg ? (meters >= limit_reg) : (meters <= limit_reg);
    end

    assign accept = in_ch.valid && in_ch.ready;
    assign start_path = in_ch.first_point || !have_prev_reg;
    assign emit = (state_reg == S_DONE) && last_reg && (!out_valid_reg || out_ch.ready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = start_path ? S_DONE : S_ANGLE;
            S_ANGLE:
                state_next = S_SCALE;
            S_SCALE:
                state_next = S_ROTATE;
            S_ROTATE:
                if (step_reg == 6'(CORDIC_LAST))
                    state_next = S_ROT_STORE;
            S_ROT_STORE:
                state_next = (job_reg == 2'd3) ? S_MUL_AA : S_ANGLE;
            S_MUL_AA:
                state_next = S_MUL_CC;
            S_MUL_CC:
                state_next = S_MUL_SS;
            S_MUL_SS:
                state_next = S_MUL_T;
            S_MUL_T:
                state_next = S_COMBINE;
            S_COMBINE:
                state_next = S_SQRT_LOAD;
            S_SQRT_LOAD:
                state_next = S_SQRT;
            S_SQRT:
                if (step_reg == 6'(SQRT_LAST))
                    state_next = (job_reg == 2'd0) ? S_SQRT_LOAD : S_VEC_LOAD;
            S_VEC_LOAD:
                state_next = S_VECTOR;
            S_VECTOR:
                if (step_reg == 6'(CORDIC_LAST))
                    state_next = S_DIST;
            S_DIST:
                state_next = S_ACCUM;
            S_ACCUM:
                state_next = S_DONE;
            S_DONE:
                if (!last_reg || emit)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ch.ready = (state_reg == S_IDLE);
        out_ch.valid = out_valid_reg;
        out_ch.path_meters = path_meters_reg;
        out_ch.limit_hit = limit_hit_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg <= '0;
            step_reg <= '0;
            have_prev_reg <= 1'b0;
            total_reg <= '0;
            prev_lat_reg <= '0;
            prev_lon_reg <= '0;
            out_valid_reg <= 1'b0;
            limit_reg <= '0;
            over_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LIMIT_METERS: limit_reg <= cfg_wdata[METERS_W-1:0];
                    CFG_OVER_MODE:    over_reg <= cfg_wdata[0];
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    job_reg <= '0;
                    if (accept && start_path)
                    begin
                        total_reg <= '0;
                        have_prev_reg <= 1'b1;
                    end
                end
                S_SCALE, S_SQRT_LOAD, S_VEC_LOAD:
                    step_reg <= '0;
                S_ROTATE, S_VECTOR, S_SQRT:
                begin
                    step_reg <= step_reg + 6'd1;
                    if ((state_reg == S_SQRT) && (step_reg == 6'(SQRT_LAST)))
                        job_reg <= job_reg + 2'd1;
                end
                S_ROT_STORE:
                    job_reg <= job_reg + 2'd1;
                S_COMBINE:
                    job_reg <= '0;
                S_ACCUM:
                    total_reg <= (acc_sum > {{(PROD_W-TOTAL_W){1'b0}}, TOTAL_MAX})
                               ? TOTAL_MAX : acc_sum[TOTAL_W-1:0];
                S_DONE:
                begin
                    prev_lat_reg <= cur_lat_reg;
                    prev_lon_reg <= cur_lon_reg;
                    if (emit)
                    begin
                        total_reg <= '0;
                        have_prev_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase

            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (accept)
        begin
            cur_lat_reg <= in_ch.latitude_e7;
            cur_lon_reg <= in_ch.longitude_e7;
            last_reg <= in_ch.last_point;
        end

        if (emit)
        begin
            path_meters_reg <= meters;
            limit_hit_reg <= hit;
        end

        unique case (state_reg)
            S_ANGLE:
                neg_reg <= ang_wrap[ANG_W-1];
            S_SCALE:
            begin
                cx_reg <= GAIN_Q32;
                cy_reg <= '0;
                cz_reg <= z_fold;
                flip_reg <= z_flip;
            end
            S_ROTATE, S_VECTOR:
            begin
                cx_reg <= cx_step;
                cy_reg <= cy_step;
                cz_reg <= cz_step;
            end
            S_ROT_STORE:
            begin
                unique case (job_reg)
                    2'd0: m1_reg <= abs_q(rot_sin);
                    2'd1: m2_reg <= abs_q(rot_sin);
                    2'd2:
                    begin
                        mc1_reg <= abs_q(rot_cos);
                        cneg1_reg <= rot_cos[CW-1];
                    end
                    2'd3:
                    begin
                        mc2_reg <= abs_q(rot_cos);
                        cneg2_reg <= rot_cos[CW-1];
                    end
                endcase
            end
            S_MUL_CC:
                a_reg <= prod_reg[64:32];
            S_MUL_SS:
                pc_reg <= prod_reg[64:32];
            S_COMBINE:
                a_reg <= a_clamped;
            S_SQRT_LOAD:
            begin
                sq_n_reg <= {1'b0, sq_in, 32'b0};
                sq_rem_reg <= '0;
                sq_root_reg <= '0;
            end
            S_SQRT:
            begin
                sq_n_reg <= sq_n_reg << 2;
                sq_rem_reg <= sq_rem_step;
                sq_root_reg <= sq_root_step;
                if (step_reg == 6'(SQRT_LAST))
                begin
                    if (job_reg == 2'd0)
                        sx_reg <= sq_root_step;
                    else
                        sy_reg <= sq_root_step;
                end
            end
            S_VEC_LOAD:
            begin
                cx_reg <= {3'b0, sx_reg};
                cy_reg <= {3'b0, sy_reg};
                cz_reg <= '0;
            end
            default:
            begin
            end
        endcase
    end

    // An accepted point always leaves idle; a start point never reaches the arithmetic sequence.
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted point did not start processing");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE && $past(last_reg))
        else $error("result raised without a last point");

    a_cordic_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROTATE || state_reg == S_VECTOR) |-> !step_reg[5])
        else $error("CORDIC step count overran");

    a_term_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SQRT_LOAD |-> a_reg <= ONE_Q32_U)
        else $error("haversine term above one");

    a_total_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> total_reg == '0 && !have_prev_reg)
        else $error("path state not cleared after result");

endmodule
